// ===== sv/bmp24_stream_blitter_defines.svh =====
// Assertion macros for the BMP stream blitter.
// Included by files that carry concurrent checks; empty when SYNTHESIS is set.
`ifndef BMP24_STREAM_BLITTER_DEFINES_SVH
`define BMP24_STREAM_BLITTER_DEFINES_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define BMP24_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bmp24 assertion failed");
// expr must never be true outside reset
`define BMP24_NEVER(label, clk, rst, expr) \
   `BMP24_ASSERT(label, clk, rst, !(expr))
`else
`define BMP24_ASSERT(label, clk, rst, prop)
`define BMP24_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== sv/bmp24_pkg.sv =====
// Shared constants, codes and types of the BMP stream blitter.
// No dependencies; used by the interfaces and all modules.
package bmp24_pkg;

   localparam int SCREEN_W = 1024;
   localparam int SCREEN_H = 768;
   localparam int MAX_DIM  = 4096;

   // stored width/height bits; values above this range only set a sticky flag
   localparam int DIM_W_RAW = $clog2(MAX_DIM + 1);
   localparam int DIM_W     = (DIM_W_RAW < 9) ? 9 : DIM_W_RAW;

   localparam int ORIGIN_W  = 12;
   localparam int COORD_W   = ((DIM_W > ORIGIN_W) ? DIM_W : ORIGIN_W) + 2;
   localparam int X_W       = 10;
   localparam int Y_W       = 10;
   localparam int COLOR_W   = 16;
   localparam int KIND_W    = 3;
   localparam int BYTE_W    = 8;
   localparam int POS_W     = 32;
   localparam int HPOS_W    = 6;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 1'b1;

   // header byte positions (little endian fields)
   localparam logic [HPOS_W-1:0] OFS_SIG    = 6'd0;
   localparam logic [HPOS_W-1:0] OFS_DATA   = 6'd10;
   localparam logic [HPOS_W-1:0] OFS_WIDTH  = 6'd18;
   localparam logic [HPOS_W-1:0] OFS_HEIGHT = 6'd22;
   localparam logic [HPOS_W-1:0] OFS_BPP    = 6'd28;
   localparam logic [HPOS_W-1:0] OFS_COMP   = 6'd30;
   localparam logic [HPOS_W-1:0] HDR_LAST   = 6'd53;
   localparam logic [POS_W-1:0]  HDR_LEN    = 32'd54;

   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
   localparam logic [15:0] BPP_24        = 16'd24;

   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXEL,
      PH_PAD,
      PH_FINISHED
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL,
      KIND_DONE,
      KIND_BAD_SIG,
      KIND_UNSUPPORTED,
      KIND_TRUNCATED
   } kind_type;

   typedef enum logic [1:0] {
      TRIPLE_BLUE,
      TRIPLE_GREEN,
      TRIPLE_RED
   } triple_type;

   typedef struct packed {
      kind_type           kind;
      logic [X_W-1:0]     pixel_x;
      logic [Y_W-1:0]     pixel_y;
      logic [COLOR_W-1:0] color;
      logic               run_end;
   } result_type;

   // results of one byte, in order: first, then second
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic signed [ORIGIN_W-1:0] x;
      logic signed [ORIGIN_W-1:0] y;
   } origin_type;

endpackage

// ===== sv/bmp24_if.sv =====
// Handshake interfaces of the BMP stream blitter: byte input, results, csr writes.
// Depends on bmp24_pkg.
interface bmp24_req_if;
   logic                           valid;
   logic                           ready;
   logic [bmp24_pkg::BYTE_W-1:0]   data_byte;
   logic                           first_byte;
   logic                           last_byte;
   modport source (output valid, data_byte, first_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface bmp24_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bmp24_pkg::KIND_W-1:0]   kind;
   logic [bmp24_pkg::X_W-1:0]      pixel_x;
   logic [bmp24_pkg::Y_W-1:0]      pixel_y;
   logic [bmp24_pkg::COLOR_W-1:0]  color;
   logic                           run_end;
   modport source (output valid, kind, pixel_x, pixel_y, color, run_end, input ready);
   modport sink   (input valid, kind, pixel_x, pixel_y, color, run_end, output ready);
endinterface

interface bmp24_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bmp24_pkg::CSR_IDX_W-1:0]  index;
   logic [bmp24_pkg::ORIGIN_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bmp24_parser.sv =====
// Input byte register and BMP parse state machine; emits up to two results per byte.
// Depends on bmp24_pkg and bmp24_req_if.
module bmp24_parser (
   input  logic                  clock,
   input  logic                  reset,
   bmp24_req_if.sink             req,
   input  bmp24_pkg::origin_type origin,
   input  logic                  space_ok,
   output bmp24_pkg::push_type   push
);

   localparam int DW = bmp24_pkg::DIM_W;
   localparam int CW = bmp24_pkg::COORD_W;

   // input word register
   logic                          in_valid_ff;
   logic [bmp24_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                          in_first_ff;
   logic                          in_last_ff;
   logic                          advance;

   // parse state
   bmp24_pkg::phase_type          phase_ff, phase_in, cur_phase;
   logic [bmp24_pkg::POS_W-1:0]   pos_ff, pos_in, cur_pos;
   logic [15:0]                   sig_ff, sig_in, cur_sig;
   logic [bmp24_pkg::POS_W-1:0]   offset_ff, offset_in, cur_offset;
   logic [DW-1:0]                 width_ff, width_in, cur_width;
   logic                          width_big_ff, width_big_in, cur_width_big;
   logic [DW-1:0]                 height_ff, height_in, cur_height;
   logic                          height_big_ff, height_big_in, cur_height_big;
   logic [15:0]                   bpp_ff, bpp_in, cur_bpp;
   logic                          comp_nz_ff, comp_nz_in, cur_comp_nz;
   logic [DW-1:0]                 row_ff, row_in, cur_row;
   logic [DW-1:0]                 col_ff, col_in, cur_col;
   bmp24_pkg::triple_type         triple_ff, triple_in, cur_triple;
   logic [1:0]                    pad_ff, pad_in, cur_pad;
   logic [15:0]                   held_ff, held_in, cur_held;

   logic [bmp24_pkg::HPOS_W-1:0]  hpos;
   logic [DW:0]                   col_next;
   logic [DW:0]                   row_next;
   logic [DW-1:0]                 flip_row;
   logic signed [CW-1:0]          sx, sy;
   logic                          visible;
   logic [bmp24_pkg::COLOR_W-1:0] color;
   logic                          pix_valid;
   logic                          ev_valid;
   bmp24_pkg::kind_type           ev_kind;
   bmp24_pkg::result_type         pix_res, ev_res;

   assign advance   = in_valid_ff && space_ok;
   assign req.ready = !in_valid_ff || space_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         in_byte_ff  <= req.data_byte;
         in_first_ff <= req.first_byte;
         in_last_ff  <= req.last_byte;
      end
   end

   // a first word restarts the parse from cleared state
   always_comb begin
      if (in_first_ff) begin
         cur_phase      = bmp24_pkg::PH_HEADER;
         cur_pos        = '0;
         cur_sig        = '0;
         cur_offset     = '0;
         cur_width      = '0;
         cur_width_big  = 1'b0;
         cur_height     = '0;
         cur_height_big = 1'b0;
         cur_bpp        = '0;
         cur_comp_nz    = 1'b0;
         cur_row        = '0;
         cur_col        = '0;
         cur_triple     = bmp24_pkg::TRIPLE_BLUE;
         cur_pad        = '0;
         cur_held       = '0;
      end else begin
         cur_phase      = phase_ff;
         cur_pos        = pos_ff;
         cur_sig        = sig_ff;
         cur_offset     = offset_ff;
         cur_width      = width_ff;
         cur_width_big  = width_big_ff;
         cur_height     = height_ff;
         cur_height_big = height_big_ff;
         cur_bpp        = bpp_ff;
         cur_comp_nz    = comp_nz_ff;
         cur_row        = row_ff;
         cur_col        = col_ff;
         cur_triple     = triple_ff;
         cur_pad        = pad_ff;
         cur_held       = held_ff;
      end
   end

   assign hpos     = cur_pos[bmp24_pkg::HPOS_W-1:0];
   assign col_next = {1'b0, cur_col} + {{DW{1'b0}}, 1'b1};
   assign row_next = {1'b0, cur_row} + {{DW{1'b0}}, 1'b1};
   assign flip_row = cur_height - cur_row - {{(DW-1){1'b0}}, 1'b1};
   assign sx = $signed({{(CW-bmp24_pkg::ORIGIN_W){origin.x[bmp24_pkg::ORIGIN_W-1]}}, origin.x})
             + $signed({{(CW-DW){1'b0}}, cur_col});
   assign sy = $signed({{(CW-bmp24_pkg::ORIGIN_W){origin.y[bmp24_pkg::ORIGIN_W-1]}}, origin.y})
             + $signed({{(CW-DW){1'b0}}, flip_row});
   assign visible = !sx[CW-1] && !sy[CW-1]
                 && (sx < $signed(CW'(bmp24_pkg::SCREEN_W)))
                 && (sy < $signed(CW'(bmp24_pkg::SCREEN_H)));
   assign color = {in_byte_ff[7:3], cur_held[15:10], cur_held[7:3]};

   always_comb begin
      phase_in      = cur_phase;
      pos_in        = cur_pos;
      sig_in        = cur_sig;
      offset_in     = cur_offset;
      width_in      = cur_width;
      width_big_in  = cur_width_big;
      height_in     = cur_height;
      height_big_in = cur_height_big;
      bpp_in        = cur_bpp;
      comp_nz_in    = cur_comp_nz;
      row_in        = cur_row;
      col_in        = cur_col;
      triple_in     = cur_triple;
      pad_in        = cur_pad;
      held_in       = cur_held;
      pix_valid     = 1'b0;
      ev_valid      = 1'b0;
      ev_kind       = bmp24_pkg::KIND_DONE;

      unique case (cur_phase)
         bmp24_pkg::PH_HEADER: begin
            pos_in = cur_pos + 32'd1;
            case (hpos)
               bmp24_pkg::OFS_SIG:             sig_in[7:0]     = in_byte_ff;
               bmp24_pkg::OFS_SIG + 6'd1:      sig_in[15:8]    = in_byte_ff;
               bmp24_pkg::OFS_DATA:            offset_in[7:0]  = in_byte_ff;
               bmp24_pkg::OFS_DATA + 6'd1:     offset_in[15:8] = in_byte_ff;
               bmp24_pkg::OFS_DATA + 6'd2:     offset_in[23:16] = in_byte_ff;
               bmp24_pkg::OFS_DATA + 6'd3:     offset_in[31:24] = in_byte_ff;
               bmp24_pkg::OFS_WIDTH:           width_in[7:0]   = in_byte_ff;
               bmp24_pkg::OFS_WIDTH + 6'd1: begin
                  width_in[DW-1:8] = in_byte_ff[DW-9:0];
                  width_big_in     = |in_byte_ff[7:DW-8];
               end
               bmp24_pkg::OFS_WIDTH + 6'd2,
               bmp24_pkg::OFS_WIDTH + 6'd3:    width_big_in = cur_width_big | (|in_byte_ff);
               bmp24_pkg::OFS_HEIGHT:          height_in[7:0] = in_byte_ff;
               bmp24_pkg::OFS_HEIGHT + 6'd1: begin
                  height_in[DW-1:8] = in_byte_ff[DW-9:0];
                  height_big_in     = |in_byte_ff[7:DW-8];
               end
               bmp24_pkg::OFS_HEIGHT + 6'd2,
               bmp24_pkg::OFS_HEIGHT + 6'd3:   height_big_in = cur_height_big | (|in_byte_ff);
               bmp24_pkg::OFS_BPP:             bpp_in[7:0]  = in_byte_ff;
               bmp24_pkg::OFS_BPP + 6'd1:      bpp_in[15:8] = in_byte_ff;
               bmp24_pkg::OFS_COMP,
               bmp24_pkg::OFS_COMP + 6'd1,
               bmp24_pkg::OFS_COMP + 6'd2,
               bmp24_pkg::OFS_COMP + 6'd3:     comp_nz_in = cur_comp_nz | (|in_byte_ff);
               default: ;
            endcase
            if (hpos == bmp24_pkg::HDR_LAST) begin
               priority if (cur_sig != bmp24_pkg::BMP_SIGNATURE) begin
                  ev_valid = 1'b1;
                  ev_kind  = bmp24_pkg::KIND_BAD_SIG;
                  phase_in = bmp24_pkg::PH_FINISHED;
               end else if (cur_bpp != bmp24_pkg::BPP_24 || cur_comp_nz
                            || cur_width_big || cur_height_big
                            || cur_width > DW'(bmp24_pkg::MAX_DIM)
                            || cur_height > DW'(bmp24_pkg::MAX_DIM)) begin
                  ev_valid = 1'b1;
                  ev_kind  = bmp24_pkg::KIND_UNSUPPORTED;
                  phase_in = bmp24_pkg::PH_FINISHED;
               end else if (cur_width == '0 || cur_height == '0) begin
                  ev_valid = 1'b1;
                  ev_kind  = bmp24_pkg::KIND_DONE;
                  phase_in = bmp24_pkg::PH_FINISHED;
               end else begin
                  phase_in = (cur_offset <= bmp24_pkg::HDR_LEN) ? bmp24_pkg::PH_PIXEL
                                                               : bmp24_pkg::PH_SKIP;
               end
            end
         end
         bmp24_pkg::PH_SKIP: begin
            // position saturates on very long files
            if (cur_pos != '1) begin
               pos_in = cur_pos + 32'd1;
            end
            if (pos_in >= cur_offset) begin
               phase_in = bmp24_pkg::PH_PIXEL;
            end
         end
         bmp24_pkg::PH_PIXEL: begin
            unique case (cur_triple)
               bmp24_pkg::TRIPLE_BLUE: begin
                  held_in[7:0] = in_byte_ff;
                  triple_in    = bmp24_pkg::TRIPLE_GREEN;
               end
               bmp24_pkg::TRIPLE_GREEN: begin
                  held_in[15:8] = in_byte_ff;
                  triple_in     = bmp24_pkg::TRIPLE_RED;
               end
               default: begin
                  pix_valid = visible;
                  triple_in = bmp24_pkg::TRIPLE_BLUE;
                  held_in   = '0;
                  col_in    = col_next[DW-1:0];
                  if (col_next >= {1'b0, cur_width}) begin
                     if (row_next >= {1'b0, cur_height}) begin
                        ev_valid = 1'b1;
                        ev_kind  = bmp24_pkg::KIND_DONE;
                        phase_in = bmp24_pkg::PH_FINISHED;
                     end else if (cur_width[1:0] != 2'd0) begin
                        pad_in   = cur_width[1:0];
                        phase_in = bmp24_pkg::PH_PAD;
                     end else begin
                        row_in = row_next[DW-1:0];
                        col_in = '0;
                     end
                  end
               end
            endcase
         end
         bmp24_pkg::PH_PAD: begin
            pad_in = cur_pad - 2'd1;
            if (pad_in == 2'd0) begin
               row_in   = row_next[DW-1:0];
               col_in   = '0;
               phase_in = bmp24_pkg::PH_PIXEL;
            end
         end
         default: ;
      endcase

      if (in_last_ff && phase_in != bmp24_pkg::PH_FINISHED) begin
         ev_valid = 1'b1;
         ev_kind  = bmp24_pkg::KIND_TRUNCATED;
         phase_in = bmp24_pkg::PH_FINISHED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= bmp24_pkg::PH_HEADER;
         pos_ff        <= '0;
         sig_ff        <= '0;
         offset_ff     <= '0;
         width_ff      <= '0;
         width_big_ff  <= 1'b0;
         height_ff     <= '0;
         height_big_ff <= 1'b0;
         bpp_ff        <= '0;
         comp_nz_ff    <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         triple_ff     <= bmp24_pkg::TRIPLE_BLUE;
         pad_ff        <= '0;
         held_ff       <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         sig_ff        <= sig_in;
         offset_ff     <= offset_in;
         width_ff      <= width_in;
         width_big_ff  <= width_big_in;
         height_ff     <= height_in;
         height_big_ff <= height_big_in;
         bpp_ff        <= bpp_in;
         comp_nz_ff    <= comp_nz_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         triple_ff     <= triple_in;
         pad_ff        <= pad_in;
         held_ff       <= held_in;
      end
   end

   // pack results; the pixel write always comes before the end event
   always_comb begin
      pix_res.kind    = bmp24_pkg::KIND_PIXEL;
      pix_res.pixel_x = sx[bmp24_pkg::X_W-1:0];
      pix_res.pixel_y = sy[bmp24_pkg::Y_W-1:0];
      pix_res.color   = color;
      pix_res.run_end = !ev_valid;
      ev_res.kind     = ev_kind;
      ev_res.pixel_x  = '0;
      ev_res.pixel_y  = '0;
      ev_res.color    = '0;
      ev_res.run_end  = 1'b1;
      push.count  = advance ? ({1'b0, pix_valid} + {1'b0, ev_valid}) : 2'd0;
      push.first  = pix_valid ? pix_res : ev_res;
      push.second = ev_res;
   end

endmodule

// ===== sv/bmp24_rsp_fifo.sv =====
// Result queue: takes up to two words per cycle, hands out one per cycle.
// Depends on bmp24_pkg and bmp24_rsp_if.
module bmp24_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  bmp24_pkg::push_type push,
   output logic                space_ok,
   bmp24_rsp_if.source         rsp
);

   localparam int PW = bmp24_pkg::OUT_PTR_W;

   bmp24_pkg::result_type mem_ff [bmp24_pkg::OUT_DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PW:0]           count_ff, count_in;
   logic [PW-1:0]         wr_ptr_up;
   logic                  pop;
   bmp24_pkg::result_type head;

   assign pop       = rsp.valid && rsp.ready;
   assign space_ok  = count_ff <= (PW+1)'(bmp24_pkg::OUT_DEPTH - 2);
   assign wr_ptr_up = wr_ptr_ff + {{(PW-1){1'b0}}, 1'b1};
   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + {{(PW-1){1'b0}}, pop};
   assign count_in  = count_ff + (PW+1)'(push.count) - {{PW{1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_up] <= push.second;
      end
   end

   assign head        = mem_ff[rd_ptr_ff];
   assign rsp.valid   = count_ff != '0;
   assign rsp.kind    = head.kind;
   assign rsp.pixel_x = head.pixel_x;
   assign rsp.pixel_y = head.pixel_y;
   assign rsp.color   = head.color;
   assign rsp.run_end = head.run_end;

endmodule

// ===== sv/bmp24_stream_blitter.sv =====
// BMP 24-bit stream blitter: one file byte per word in, pixel writes and status out.
// Throughput one byte per cycle while the queue has room. A byte taken into the input
// register is parsed there and queued once the queue has room; its results are then
// valid, at most two per byte, drained one per cycle from a four-word queue on ready.
// The input register stalls only while that queue holds more than two words.
// Synchronous active-high reset clears the parse state, the queue and both origins.
`include "bmp24_stream_blitter_defines.svh"
module bmp24_stream_blitter (
   input  logic        clock,
   input  logic        reset,
   bmp24_req_if.sink   req_chan,
   bmp24_rsp_if.source rsp_chan,
   bmp24_csr_if.sink   csr_chan
);

   bmp24_pkg::origin_type origin_ff;
   bmp24_pkg::push_type   push;
   logic                  space_ok;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            bmp24_pkg::CSR_ORIGIN_X: origin_ff.x <= $signed(csr_chan.data);
            bmp24_pkg::CSR_ORIGIN_Y: origin_ff.y <= $signed(csr_chan.data);
         endcase
      end
   end

   bmp24_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .origin   (origin_ff),
      .space_ok (space_ok),
      .push     (push)
   );

   bmp24_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_chan)
   );

   `BMP24_ASSERT(a_push_has_room, clock, reset, (push.count != 2'd0 |-> space_ok))
   `BMP24_ASSERT(a_pair_order, clock, reset,
      (push.count == 2'd2 |-> push.second.run_end && !push.first.run_end
                              && push.first.kind == bmp24_pkg::KIND_PIXEL))
   `BMP24_NEVER(a_status_fields_zero, clock, reset,
      rsp_chan.valid && rsp_chan.kind != bmp24_pkg::KIND_PIXEL
      && (rsp_chan.pixel_x != '0 || rsp_chan.pixel_y != '0 || rsp_chan.color != '0))
   `BMP24_NEVER(a_pixel_on_screen, clock, reset,
      rsp_chan.valid && rsp_chan.kind == bmp24_pkg::KIND_PIXEL
      && rsp_chan.pixel_y >= bmp24_pkg::Y_W'(bmp24_pkg::SCREEN_H))

endmodule
